### rtl/sdspi_pkg.sv
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int IDX_W = $clog2(BLOCK_BYTES + 1);

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_XCHG  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_R1    = 3'd0,
    KIND_R1X   = 3'd1,
    KIND_READ  = 3'd2,
    KIND_READM = 3'd3,
    KIND_WRITE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_READY_TO = 2'd1,
    ST_TOKEN_TO = 2'd2,
    ST_REJECT   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_BEGIN, PH_CMD, PH_RESP, PH_EXTRA, PH_TOKEN, PH_DATA, PH_CRC,
    PH_STOPCMD, PH_STUFF, PH_STOPRESP, PH_WREADY, PH_WTOKEN, PH_WDATA,
    PH_WCRC, PH_WRESP, PH_BUSY, PH_END_OK, PH_END_READY, PH_END_REJECT
  } phase_t;

  localparam logic [1:0] CFG_READY_TO = 2'd0;
  localparam logic [1:0] CFG_TOKEN_TO = 2'd1;

  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] TOKEN_DATA = 8'hFE;
  localparam logic [5:0] CMD_STOP   = 6'd12;
  localparam logic [7:0] CRC_STOP   = 8'h01;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        chip_select;
    logic [7:0]  rx_data_byte;
    logic        rx_data_valid;
    logic        write_byte_taken;
    logic [7:0]  response;
    logic [31:0] extra_response;
    logic [15:0] blocks_done;
    logic [1:0]  status;
    logic        done_res;
  } result_t;

  function automatic logic [7:0] frame_byte(input logic [IDX_W-1:0] idx,
                                            input logic [5:0] cmd,
                                            input logic [31:0] arg,
                                            input logic [7:0] crc);
    logic [7:0] b;
    case (idx)
      IDX_W'(0): b = {2'b01, cmd};
      IDX_W'(1): b = arg[31:24];
      IDX_W'(2): b = arg[23:16];
      IDX_W'(3): b = arg[15:8];
      IDX_W'(4): b = arg[7:0];
      default:   b = crc;
    endcase
    return b;
  endfunction

endpackage

### rtl/sdspi_seq.sv
module sdspi_seq import sdspi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        func,
  input  logic [7:0]        rx_byte,
  input  logic [5:0]        command_index,
  input  logic [31:0]       argument,
  input  logic [7:0]        crc_byte,
  input  logic [2:0]        transfer_kind,
  input  logic [15:0]       block_count,
  input  logic [7:0]        write_byte,
  input  logic [7:0]        ready_to,
  input  logic [7:0]        token_to,
  output logic              res_valid,
  output result_t           res
);

  phase_t            phase_r, phase_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [7:0]        tmo_r, tmo_nxt;
  logic [3:0]        poll_r, poll_nxt;
  logic [15:0]       left_r, left_nxt;
  logic [15:0]       read_r, read_nxt;
  logic [7:0]        sresp_r, sresp_nxt;
  logic [31:0]       extra_r, extra_nxt;
  logic [5:0]        cmd_r, cmd_nxt;
  logic [31:0]       arg_r, arg_nxt;
  logic [7:0]        crc_r, crc_nxt;
  kind_t             kind_r, kind_nxt;
  logic [IDX_W-1:0]  rlen;
  logic [IDX_W-1:0]  idx_inc;
  result_t           r;
  logic              emit;

  assign idx_inc = idx_r + IDX_W'(1);

  always_comb begin
    rlen = IDX_W'(BLOCK_BYTES);
    if (kind_r == KIND_READ) begin
      if (cmd_r == 6'd9 || cmd_r == 6'd10) rlen = IDX_W'(16);
      else if (cmd_r == 6'd6) rlen = IDX_W'(64);
    end
  end

  always_comb begin
    phase_nxt = phase_r; idx_nxt = idx_r; tmo_nxt = tmo_r; poll_nxt = poll_r;
    left_nxt = left_r; read_nxt = read_r; sresp_nxt = sresp_r; extra_nxt = extra_r;
    cmd_nxt = cmd_r; arg_nxt = arg_r; crc_nxt = crc_r; kind_nxt = kind_r;
    r = '0;
    emit = 1'b0;
    case (func_t'(func))
      FUNC_TICK: begin
        if (tmo_r != 8'd0) tmo_nxt = tmo_r - 8'd1;
      end
      FUNC_START: begin
        if (phase_r == PH_IDLE) begin
          emit = 1'b1;
          cmd_nxt = command_index;
          arg_nxt = argument;
          crc_nxt = crc_byte;
          kind_nxt = (transfer_kind > 3'd4) ? KIND_R1 : kind_t'(transfer_kind);
          left_nxt = block_count;
          read_nxt = '0;
          extra_nxt = '0;
          sresp_nxt = BYTE_IDLE;
          idx_nxt = '0;
          poll_nxt = '0;
          tmo_nxt = ready_to;
          phase_nxt = PH_BEGIN;
          r.tx_byte = BYTE_IDLE; r.tx_valid = 1'b1;
        end
      end
      FUNC_XCHG: begin
        emit = 1'b1;
        r.tx_byte = BYTE_IDLE; r.tx_valid = 1'b1;
        case (phase_r)
          PH_BEGIN: begin
            if (rx_byte == BYTE_IDLE) begin
              idx_nxt = '0; phase_nxt = PH_CMD;
              r.tx_byte = frame_byte('0, cmd_r, arg_r, crc_r);
            end else if (tmo_r == 8'd0) begin
              r.tx_valid = 1'b0; r.tx_byte = '0; r.chip_select = 1'b1;
              r.done_res = 1'b1; r.response = BYTE_IDLE; r.status = ST_READY_TO;
              r.extra_response = extra_r; phase_nxt = PH_IDLE;
            end
          end
          PH_CMD: begin
            idx_nxt = idx_inc;
            if (idx_inc < IDX_W'(6)) r.tx_byte = frame_byte(idx_inc, cmd_r, arg_r, crc_r);
            else begin poll_nxt = '0; phase_nxt = PH_RESP; end
          end
          PH_RESP, PH_STOPRESP: begin
            if (rx_byte[7] && poll_r < 4'd8) poll_nxt = poll_r + 4'd1;
            else if (phase_r == PH_STOPRESP) begin
              r.chip_select = 1'b1; phase_nxt = PH_END_OK;
            end else begin
              sresp_nxt = rx_byte;
              case (kind_r)
                KIND_R1X: begin
                  if (rx_byte[7:1] == 7'd0) begin idx_nxt = '0; phase_nxt = PH_EXTRA; end
                  else begin r.chip_select = 1'b1; phase_nxt = PH_END_OK; end
                end
                KIND_READ: begin
                  if (rx_byte == 8'd0) begin tmo_nxt = token_to; phase_nxt = PH_TOKEN; end
                  else begin r.chip_select = 1'b1; phase_nxt = PH_END_OK; end
                end
                KIND_READM: begin
                  if (rx_byte != 8'd0) begin r.chip_select = 1'b1; phase_nxt = PH_END_OK; end
                  else if (left_r == 16'd0) begin
                    idx_nxt = '0; phase_nxt = PH_STOPCMD;
                    r.tx_byte = frame_byte('0, CMD_STOP, '0, CRC_STOP);
                  end else begin tmo_nxt = token_to; phase_nxt = PH_TOKEN; end
                end
                KIND_WRITE: begin
                  if (rx_byte == 8'd0) begin tmo_nxt = ready_to; phase_nxt = PH_WREADY; end
                  else begin r.chip_select = 1'b1; phase_nxt = PH_END_OK; end
                end
                default: begin r.chip_select = 1'b1; phase_nxt = PH_END_OK; end
              endcase
            end
          end
          PH_EXTRA: begin
            extra_nxt = {extra_r[23:0], rx_byte};
            idx_nxt = idx_inc;
            if (idx_inc >= IDX_W'(4)) begin r.chip_select = 1'b1; phase_nxt = PH_END_OK; end
          end
          PH_TOKEN: begin
            if (rx_byte == TOKEN_DATA) begin idx_nxt = '0; phase_nxt = PH_DATA; end
            else if (tmo_r == 8'd0) begin
              r.tx_valid = 1'b0; r.tx_byte = '0; r.chip_select = 1'b1;
              r.done_res = 1'b1; r.response = BYTE_IDLE; r.status = ST_TOKEN_TO;
              r.extra_response = extra_r; phase_nxt = PH_IDLE;
            end
          end
          PH_DATA: begin
            r.rx_data_byte = rx_byte; r.rx_data_valid = 1'b1;
            idx_nxt = idx_inc;
            if (idx_inc >= rlen) begin idx_nxt = '0; phase_nxt = PH_CRC; end
          end
          PH_CRC: begin
            if (idx_r == '0) idx_nxt = IDX_W'(1);
            else if (kind_r == KIND_READM) begin
              read_nxt = read_r + 16'd1;
              left_nxt = left_r - 16'd1;
              if (left_r == 16'd1) begin
                idx_nxt = '0; phase_nxt = PH_STOPCMD;
                r.tx_byte = frame_byte('0, CMD_STOP, '0, CRC_STOP);
              end else begin tmo_nxt = token_to; phase_nxt = PH_TOKEN; end
            end else begin r.chip_select = 1'b1; phase_nxt = PH_END_OK; end
          end
          PH_STOPCMD: begin
            idx_nxt = idx_inc;
            if (idx_inc < IDX_W'(6)) r.tx_byte = frame_byte(idx_inc, CMD_STOP, '0, CRC_STOP);
            else phase_nxt = PH_STUFF;
          end
          PH_STUFF: begin
            poll_nxt = '0; phase_nxt = PH_STOPRESP;
          end
          PH_WREADY: begin
            if (rx_byte == BYTE_IDLE) begin phase_nxt = PH_WTOKEN; r.tx_byte = TOKEN_DATA; end
            else if (tmo_r == 8'd0) begin r.chip_select = 1'b1; phase_nxt = PH_END_READY; end
          end
          PH_WTOKEN: begin
            r.tx_byte = write_byte; r.write_byte_taken = 1'b1;
            idx_nxt = IDX_W'(1); phase_nxt = PH_WDATA;
          end
          PH_WDATA: begin
            if (idx_r < IDX_W'(BLOCK_BYTES)) begin
              r.tx_byte = write_byte; r.write_byte_taken = 1'b1; idx_nxt = idx_inc;
            end else begin idx_nxt = '0; phase_nxt = PH_WCRC; end
          end
          PH_WCRC: begin
            if (idx_r == '0) idx_nxt = IDX_W'(1);
            else phase_nxt = PH_WRESP;
          end
          PH_WRESP: begin
            if (rx_byte[4:0] == 5'h05) phase_nxt = PH_BUSY;
            else begin r.chip_select = 1'b1; phase_nxt = PH_END_REJECT; end
          end
          PH_BUSY: begin
            if (rx_byte != 8'd0) begin r.chip_select = 1'b1; phase_nxt = PH_END_OK; end
          end
          PH_END_OK, PH_END_READY, PH_END_REJECT: begin
            r.tx_valid = 1'b0; r.tx_byte = '0; r.chip_select = 1'b1;
            r.done_res = 1'b1; r.extra_response = extra_r; phase_nxt = PH_IDLE;
            if (phase_r == PH_END_OK) begin r.response = sresp_r; r.status = ST_OK; end
            else if (phase_r == PH_END_READY) begin
              r.response = BYTE_IDLE; r.status = ST_READY_TO;
            end else begin r.response = BYTE_IDLE; r.status = ST_REJECT; end
          end
          default: begin
            emit = 1'b0; r.tx_valid = 1'b0; r.tx_byte = '0; phase_nxt = PH_IDLE;
          end
        endcase
      end
      default: ;
    endcase
    r.blocks_done = read_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; idx_r <= '0; tmo_r <= '0; poll_r <= '0; left_r <= '0;
      read_r <= '0; sresp_r <= BYTE_IDLE; extra_r <= '0; cmd_r <= '0; arg_r <= '0;
      crc_r <= '0; kind_r <= KIND_R1;
    end else if (step) begin
      phase_r <= phase_nxt; idx_r <= idx_nxt; tmo_r <= tmo_nxt; poll_r <= poll_nxt;
      left_r <= left_nxt; read_r <= read_nxt; sresp_r <= sresp_nxt; extra_r <= extra_nxt;
      cmd_r <= cmd_nxt; arg_r <= arg_nxt; crc_r <= crc_nxt; kind_r <= kind_nxt;
    end
  end

  assign res_valid = step & emit;
  assign res = r;

endmodule

### rtl/sd_spi_command_transaction_core.sv
// channel | direction | handshake           | payload
// in_     | input     | in_valid/in_stall   | func, rx_byte, command, argument, crc, kind, ...
// out_    | output    | out_valid/out_stall | tx byte, chip select, data byte, response, status
// cfg_    | input     | cfg_we              | ready/token timeout in ms
// each item is processed in the cycle it is accepted; any result appears in the next cycle
// in an output register, so one item per cycle is sustained while out_stall is low
// in_stall is high only while a result is held back by out_stall
// synchronous active-low reset: idle phase, timeouts 10 ms and 100 ms
module sd_spi_command_transaction_core import sdspi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_rx_byte,
  input  logic [5:0]  in_command_index,
  input  logic [31:0] in_argument,
  input  logic [7:0]  in_crc_byte,
  input  logic [2:0]  in_transfer_kind,
  input  logic [15:0] in_block_count,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_valid,
  output logic        out_chip_select,
  output logic [7:0]  out_rx_data_byte,
  output logic        out_rx_data_valid,
  output logic        out_write_byte_taken,
  output logic [7:0]  out_response,
  output logic [31:0] out_extra_response,
  output logic [15:0] out_blocks_done,
  output logic [1:0]  out_status,
  output logic        out_done_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] ready_to_r, token_to_r;
  logic       step, res_valid;
  result_t    res, out_r;
  logic       out_valid_r;

  assign in_stall = out_valid_r & out_stall;
  assign step = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_to_r <= 8'd10;
      token_to_r <= 8'd100;
    end else if (cfg_we) begin
      if (cfg_index == CFG_READY_TO) ready_to_r <= cfg_data;
      else if (cfg_index == CFG_TOKEN_TO) token_to_r <= cfg_data;
    end
  end

  sdspi_seq u_seq (
    .clk, .rst_n, .step,
    .func(in_func), .rx_byte(in_rx_byte), .command_index(in_command_index),
    .argument(in_argument), .crc_byte(in_crc_byte), .transfer_kind(in_transfer_kind),
    .block_count(in_block_count), .write_byte(in_write_byte),
    .ready_to(ready_to_r), .token_to(token_to_r),
    .res_valid, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && res_valid) out_r <= res;
  end

  assign out_valid            = out_valid_r;
  assign out_tx_byte          = out_r.tx_byte;
  assign out_tx_valid         = out_r.tx_valid;
  assign out_chip_select      = out_r.chip_select;
  assign out_rx_data_byte     = out_r.rx_data_byte;
  assign out_rx_data_valid    = out_r.rx_data_valid;
  assign out_write_byte_taken = out_r.write_byte_taken;
  assign out_response         = out_r.response;
  assign out_extra_response   = out_r.extra_response;
  assign out_blocks_done      = out_r.blocks_done;
  assign out_status           = out_r.status;
  assign out_done_res         = out_r.done_res;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with empty output register");
  a_done_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_tx_valid && out_chip_select)
    else $error("end beat requests a byte");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) && rst_n && $past(rst_n) |-> out_valid)
    else $error("stalled result dropped");

endmodule

### test/sd_spi_command_transaction_core_tb.sv
module sd_spi_command_transaction_core_tb import sdspi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1050;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_NONE;
  logic [7:0]  in_rx_byte = '0;
  logic [5:0]  in_command_index = '0;
  logic [31:0] in_argument = '0;
  logic [7:0]  in_crc_byte = '0;
  logic [2:0]  in_transfer_kind = '0;
  logic [15:0] in_block_count = '0;
  logic [7:0]  in_write_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_tx_valid;
  logic        out_chip_select;
  logic [7:0]  out_rx_data_byte;
  logic        out_rx_data_valid;
  logic        out_write_byte_taken;
  logic [7:0]  out_response;
  logic [31:0] out_extra_response;
  logic [15:0] out_blocks_done;
  logic [1:0]  out_status;
  logic        out_done_res;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_READY_TO;
  logic [7:0]  cfg_data = '0;

  sd_spi_command_transaction_core dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // transaction predictor state
  logic [7:0]  ready_ms = 8'd10;
  logic [7:0]  token_ms = 8'd100;
  phase_t      ph = PH_IDLE;
  logic [15:0] idx = '0;
  logic [7:0]  tleft = '0;
  logic [3:0]  polls = '0;
  logic [15:0] bleft = '0;
  logic [15:0] bread = '0;
  logic [7:0]  sresp = 8'hFF;
  logic [31:0] xshift = '0;
  logic [5:0]  scmd = '0;
  logic [31:0] sarg = '0;
  logic [7:0]  scrc = '0;
  kind_t       skind = KIND_R1;
  result_t     pr;

  result_t expected_beats[$];
  int errors = 0;
  int n_items = 0;
  int cycles = 0;
  bit gap_on = 1'b0;
  bit stall_on = 1'b0;
  int hold_req = 0;

  // card behavior knobs
  int r1_force = -1;
  int bad_ready = 10;
  int bad_token = 10;
  int reject_pct = 20;
  int tick_pct = 5;
  int noise_pct = 3;

  function automatic bit pct(int p);
    return $urandom_range(0, 99) < p;
  endfunction

  function automatic logic [7:0] fbyte(int i, logic [5:0] c, logic [31:0] a, logic [7:0] k);
    if (i == 0) return {2'b01, c};
    if (i >= 5) return k;
    return 8'(a >> (8 * (4 - i)));
  endfunction

  function automatic logic [15:0] read_len();
    if (skind == KIND_READ) begin
      if (scmd == 6'd9 || scmd == 6'd10) return 16'd16;
      if (scmd == 6'd6) return 16'd64;
    end
    return 16'(BLOCK_BYTES);
  endfunction

  function void put_byte(logic [7:0] b);
    pr.tx_byte = b;
    pr.tx_valid = 1'b1;
  endfunction

  function void close_with(phase_t p);
    pr.chip_select = 1'b1;
    put_byte(BYTE_IDLE);
    ph = p;
  endfunction

  function void end_txn(logic [7:0] resp, status_t st);
    pr.chip_select = 1'b1;
    pr.tx_valid = 1'b0;
    pr.tx_byte = '0;
    pr.done_res = 1'b1;
    pr.response = resp;
    pr.status = st;
    pr.extra_response = xshift;
    ph = PH_IDLE;
  endfunction

  function void stop_frame();
    idx = '0;
    ph = PH_STOPCMD;
    put_byte(fbyte(0, CMD_STOP, 32'd0, CRC_STOP));
  endfunction

  function void wait_token();
    tleft = token_ms;
    ph = PH_TOKEN;
    put_byte(BYTE_IDLE);
  endfunction

  function void after_r1(logic [7:0] rx);
    sresp = rx;
    case (skind)
      KIND_R1X: begin
        if ((rx & 8'hFE) == 0) begin
          idx = '0;
          ph = PH_EXTRA;
          put_byte(BYTE_IDLE);
        end else close_with(PH_END_OK);
      end
      KIND_READ: if (rx == 0) wait_token(); else close_with(PH_END_OK);
      KIND_READM: begin
        if (rx != 0) close_with(PH_END_OK);
        else if (bleft == 0) stop_frame();
        else wait_token();
      end
      KIND_WRITE: begin
        if (rx == 0) begin
          tleft = ready_ms;
          ph = PH_WREADY;
          put_byte(BYTE_IDLE);
        end else close_with(PH_END_OK);
      end
      default: close_with(PH_END_OK);
    endcase
  endfunction

  // advance the transaction state by one beat; returns 1 when a result is due
  function automatic bit sd_advance(logic [1:0] f, logic [7:0] rx, logic [5:0] c,
                                    logic [31:0] a, logic [7:0] k, logic [2:0] kd,
                                    logic [15:0] cnt, logic [7:0] wb);
    pr = '0;
    if (f == FUNC_TICK) begin
      if (tleft > 0) tleft--;
      return 1'b0;
    end
    if (f == FUNC_START) begin
      if (ph != PH_IDLE) return 1'b0;
      scmd = c;
      sarg = a;
      scrc = k;
      skind = (kd > 3'd4) ? KIND_R1 : kind_t'(kd);
      bleft = cnt;
      bread = '0;
      xshift = '0;
      sresp = BYTE_IDLE;
      idx = '0;
      polls = '0;
      tleft = ready_ms;
      ph = PH_BEGIN;
      put_byte(BYTE_IDLE);
    end else if (f == FUNC_XCHG) begin
      case (ph)
        PH_BEGIN: begin
          if (rx == BYTE_IDLE) begin
            idx = '0;
            ph = PH_CMD;
            put_byte(fbyte(0, scmd, sarg, scrc));
          end else if (tleft == 0) end_txn(BYTE_IDLE, ST_READY_TO);
          else put_byte(BYTE_IDLE);
        end
        PH_CMD: begin
          idx++;
          if (idx < 6) put_byte(fbyte(idx, scmd, sarg, scrc));
          else begin
            polls = '0;
            ph = PH_RESP;
            put_byte(BYTE_IDLE);
          end
        end
        PH_RESP: begin
          if (rx[7] && polls < 8) begin
            polls++;
            put_byte(BYTE_IDLE);
          end else after_r1(rx);
        end
        PH_EXTRA: begin
          xshift = {xshift[23:0], rx};
          idx++;
          if (idx >= 4) close_with(PH_END_OK); else put_byte(BYTE_IDLE);
        end
        PH_TOKEN: begin
          if (rx == TOKEN_DATA) begin
            idx = '0;
            ph = PH_DATA;
            put_byte(BYTE_IDLE);
          end else if (tleft == 0) end_txn(BYTE_IDLE, ST_TOKEN_TO);
          else put_byte(BYTE_IDLE);
        end
        PH_DATA: begin
          pr.rx_data_byte = rx;
          pr.rx_data_valid = 1'b1;
          idx++;
          if (idx >= read_len()) begin
            idx = '0;
            ph = PH_CRC;
          end
          put_byte(BYTE_IDLE);
        end
        PH_CRC: begin
          if (idx == 0) begin
            idx = 1;
            put_byte(BYTE_IDLE);
          end else if (skind == KIND_READM) begin
            bread++;
            bleft--;
            if (bleft == 0) stop_frame(); else wait_token();
          end else close_with(PH_END_OK);
        end
        PH_STOPCMD: begin
          idx++;
          if (idx < 6) put_byte(fbyte(idx, CMD_STOP, 32'd0, CRC_STOP));
          else begin
            ph = PH_STUFF;
            put_byte(BYTE_IDLE);
          end
        end
        PH_STUFF: begin
          polls = '0;
          ph = PH_STOPRESP;
          put_byte(BYTE_IDLE);
        end
        PH_STOPRESP: begin
          if (rx[7] && polls < 8) begin
            polls++;
            put_byte(BYTE_IDLE);
          end else close_with(PH_END_OK);
        end
        PH_WREADY: begin
          if (rx == BYTE_IDLE) begin
            ph = PH_WTOKEN;
            put_byte(TOKEN_DATA);
          end else if (tleft == 0) close_with(PH_END_READY);
          else put_byte(BYTE_IDLE);
        end
        PH_WTOKEN: begin
          put_byte(wb);
          pr.write_byte_taken = 1'b1;
          idx = 1;
          ph = PH_WDATA;
        end
        PH_WDATA: begin
          if (idx < BLOCK_BYTES) begin
            put_byte(wb);
            pr.write_byte_taken = 1'b1;
            idx++;
          end else begin
            idx = '0;
            ph = PH_WCRC;
            put_byte(BYTE_IDLE);
          end
        end
        PH_WCRC: begin
          if (idx == 0) begin
            idx = 1;
            put_byte(BYTE_IDLE);
          end else begin
            ph = PH_WRESP;
            put_byte(BYTE_IDLE);
          end
        end
        PH_WRESP: begin
          if (rx[4:0] == 5'h05) begin
            ph = PH_BUSY;
            put_byte(BYTE_IDLE);
          end else close_with(PH_END_REJECT);
        end
        PH_BUSY: if (rx == 0) put_byte(BYTE_IDLE); else close_with(PH_END_OK);
        PH_END_OK: end_txn(sresp, ST_OK);
        PH_END_READY: end_txn(BYTE_IDLE, ST_READY_TO);
        PH_END_REJECT: end_txn(BYTE_IDLE, ST_REJECT);
        default: begin
          ph = PH_IDLE;
          return 1'b0;
        end
      endcase
    end else return 1'b0;
    pr.blocks_done = bread;
    return 1'b1;
  endfunction

  task automatic send_beat(logic [1:0] f, logic [7:0] rx, logic [5:0] c, logic [31:0] a,
                           logic [7:0] k, logic [2:0] kd, logic [15:0] cnt, logic [7:0] wb);
    if (gap_on && pct(10)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_rx_byte <= rx;
    in_command_index <= c;
    in_argument <= a;
    in_crc_byte <= k;
    in_transfer_kind <= kd;
    in_block_count <= cnt;
    in_write_byte <= wb;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (sd_advance(f, rx, c, a, k, kd, cnt, wb)) expected_beats.push_back(pr);
  endtask

  task automatic send_noise(logic [1:0] f);
    send_beat(f, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] which, logic [7:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_READY_TO) ready_ms = val; else token_ms = val;
  endtask

  function automatic logic [7:0] not_byte(logic [7:0] avoid);
    logic [7:0] b;
    b = $urandom;
    if (b == avoid) b = ~avoid;
    return b;
  endfunction

  // what an SD card would answer in the current phase
  function automatic logic [7:0] card_byte();
    case (ph)
      PH_BEGIN, PH_WREADY: return pct(bad_ready) ? not_byte(BYTE_IDLE) : BYTE_IDLE;
      PH_RESP, PH_STOPRESP: begin
        if (pct(35)) return 8'h80 | 8'($urandom);
        if (r1_force >= 0) return 8'(r1_force);
        if (pct(80)) return 8'h00;
        return pct(50) ? 8'h01 : 8'($urandom_range(0, 127));
      end
      PH_TOKEN: return pct(bad_token) ? not_byte(TOKEN_DATA) : TOKEN_DATA;
      PH_WRESP: begin
        if (pct(reject_pct)) return {3'($urandom), not_byte(8'h05)} & 8'hE0
                                   | (not_byte(8'h05) & 8'h1F) | 8'h10;
        return {3'($urandom), 5'h05};
      end
      PH_BUSY: return pct(60) ? 8'h00 : not_byte(8'h00);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_txn(logic [5:0] c, logic [31:0] a, logic [7:0] k, logic [2:0] kd,
                         logic [15:0] cnt);
    send_beat(FUNC_START, $urandom, c, a, k, kd, cnt, $urandom);
    while (ph != PH_IDLE) begin
      if (pct(tick_pct)) send_noise(FUNC_TICK);
      if (pct(noise_pct)) send_noise(pct(50) ? FUNC_START : FUNC_NONE);
      send_beat(FUNC_XCHG, card_byte(), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("beat mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) report_mismatch("unexpected beat", 0, 0);
      else begin
        e = expected_beats.pop_front();
        check_field("tx_byte", out_tx_byte, e.tx_byte);
        check_field("tx_valid", out_tx_valid, e.tx_valid);
        check_field("chip_select", out_chip_select, e.chip_select);
        check_field("rx_data_byte", out_rx_data_byte, e.rx_data_byte);
        check_field("rx_data_valid", out_rx_data_valid, e.rx_data_valid);
        check_field("write_byte_taken", out_write_byte_taken, e.write_byte_taken);
        check_field("response", out_response, e.response);
        check_field("extra_response", out_extra_response, e.extra_response);
        check_field("blocks_done", out_blocks_done, e.blocks_done);
        check_field("status", out_status, e.status);
        check_field("done_res", out_done_res, e.done_res);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (stall_on && pct(10)) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_frames();
    write_reg(CFG_READY_TO, 8'd255);
    write_reg(CFG_TOKEN_TO, 8'd255);
    r1_force = 0;
    run_txn(6'd0, 32'h0, 8'h00, KIND_R1, 16'd1);
    run_txn(6'd63, 32'hFFFF_FFFF, 8'hFF, KIND_R1, 16'hFFFF);
    run_txn(6'd1, 32'h1234_5678, 8'h95, 3'd5, 16'd0);
    run_txn(6'd2, 32'h8000_0001, 8'h87, 3'd7, 16'd0);
    r1_force = 1;
    run_txn(6'd8, 32'h0000_01AA, 8'h87, KIND_R1X, 16'd1);
    r1_force = 4;
    run_txn(6'd58, 32'h0, 8'h01, KIND_R1X, 16'd1);
    r1_force = 0;
    run_txn(6'd9, 32'h0, 8'h01, KIND_READ, 16'd1);
    run_txn(6'd10, 32'h0, 8'h01, KIND_READ, 16'd1);
    run_txn(6'd6, 32'h80FF_FFF1, 8'h01, KIND_READ, 16'd1);
    run_txn(6'd18, 32'h100, 8'h01, KIND_READM, 16'd0);
    r1_force = 5;
    run_txn(6'd17, 32'h200, 8'h01, KIND_READ, 16'd1);
    r1_force = -1;
  endtask

  task automatic test_timeouts();
    write_reg(CFG_READY_TO, 8'd1);
    write_reg(CFG_TOKEN_TO, 8'd1);
    bad_ready = 90;
    tick_pct = 50;
    run_txn(6'd0, 32'h0, 8'h95, KIND_R1, 16'd1);
    bad_ready = 0;
    bad_token = 95;
    r1_force = 0;
    run_txn(6'd9, 32'h0, 8'h01, KIND_READ, 16'd1);
    bad_ready = 10;
    bad_token = 10;
    tick_pct = 5;
    r1_force = -1;
  endtask

  task automatic test_ignored();
    drain();
    send_noise(FUNC_XCHG);
    send_noise(FUNC_NONE);
    send_noise(FUNC_TICK);
    noise_pct = 60;
    run_txn(6'd13, 32'h0, 8'h01, KIND_R1, 16'd1);
    noise_pct = 3;
  endtask

  task automatic test_pressure();
    drain();
    hold_req = 80;
    run_txn(6'd9, $urandom, 8'h01, KIND_READ, 16'd1);
    drain();
  endtask

  task automatic test_random();
    int k;
    int t;
    int txn;
    logic [5:0] c;
    logic [15:0] cnt;
    gap_on = 1'b1;
    stall_on = 1'b1;
    txn = 0;
    while (n_items < ITEM_TARGET) begin
      if (n_items > ITEM_TARGET * 4 / 5) begin
        gap_on = 1'b0;
        stall_on = 1'b0;
      end
      if (txn % 15 == 14) begin
        t = $urandom_range(0, 3);
        write_reg(CFG_READY_TO, t == 0 ? 8'd1 : t == 1 ? 8'd255 : 8'($urandom_range(1, 4)));
        t = $urandom_range(0, 3);
        write_reg(CFG_TOKEN_TO, t == 0 ? 8'd1 : t == 1 ? 8'd255 : 8'($urandom_range(1, 4)));
      end
      c = $urandom;
      cnt = $urandom;
      k = $urandom_range(0, 7);
      if (k == KIND_READ) begin
        t = $urandom_range(0, 9);
        c = (t < 4) ? 6'd9 : (t < 7) ? 6'd10 : (t < 9) ? 6'd6 : 6'd17;
      end else if (k == KIND_READM) begin
        if (pct(25)) cnt = $urandom_range(0, 2); else k = KIND_R1X;
      end else if (k == KIND_WRITE && !pct(25)) k = KIND_R1;
      // keep full-block transfers away from the end of the run
      if (n_items + 560 > ITEM_TARGET) begin
        if (k == KIND_READM || k == KIND_WRITE) k = KIND_R1;
        else if (k == KIND_READ && c == 6'd17) c = 6'd9;
      end
      run_txn(c, $urandom, $urandom, 3'(k), cnt);
      txn++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_frames();
    test_timeouts();
    test_ignored();
    test_pressure();
    test_random();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
rtl/sdspi_pkg.sv
rtl/sdspi_seq.sv
rtl/sd_spi_command_transaction_core.sv
test/sd_spi_command_transaction_core_tb.sv
